[hdl/icph_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icph_pkg: shared types and a helper for the internet checksum block
// Transfer types for both channels, the queue entry passed from the front
// end to the back end, and the end-around-carry fold.
// ----------------------------------------------------------------------------
package icph_pkg;

    localparam int unsigned QueueDepthDefault = 2;

    // One packet byte with its framing and pseudo header fields.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_of_packet;
        logic        last_of_packet;
        logic        use_pseudo_header;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  protocol;
    } icph_in_t;

    // One finished checksum.
    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] byte_count;
    } icph_out_t;

    // A classified byte as it waits in the queue.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first;
        logic        last;
        logic        pseudo;
        logic [15:0] pseudo_sum;
    } icph_entry_t;

    // Queue status seen by the two ends.
    typedef struct packed {
        logic full;
        logic empty;
    } icph_qstat_t;

    // Folds a sum of up to eight 16-bit words back into 16 bits with
    // end-around carry. Zero stays zero; any other total maps into 1..0xffff.
    function automatic logic [15:0] oc_fold(input logic [18:0] total);
        logic [16:0] once;
        logic [15:0] twice;
        once  = {1'b0, total[15:0]} + 17'(total[18:16]);
        twice = once[15:0] + 16'(once[16]);
        return twice;
    endfunction

endpackage
`default_nettype wire

[hdl/icph_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icph_front: input stage of the checksum block
// Registers each byte, works out the folded pseudo header sum for a first
// byte and pushes the classified entry into the queue.
// ----------------------------------------------------------------------------
module icph_front
    import icph_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire icph_in_t    item,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire icph_qstat_t qstat,
    output logic             push,
    output icph_entry_t      push_entry
);

    logic        valid_reg;
    logic        valid_next;
    icph_entry_t entry_reg;
    icph_entry_t entry_next;
    logic        accept;
    logic [18:0] pseudo_total;

    assign item_stall = valid_reg && qstat.full;
    assign accept     = item_valid && !item_stall;
    assign push       = valid_reg && !qstat.full;
    assign push_entry = entry_reg;

    // Five pseudo header words: both address halves of each address and 0x00pp.
    always_comb
    begin
        pseudo_total = 19'(item.source_address[31:16]) + 19'(item.source_address[15:0])
                     + 19'(item.dest_address[31:16]) + 19'(item.dest_address[15:0])
                     + 19'(item.protocol);
    end

    always_comb
    begin
        entry_next.data_byte  = item.data_byte;
        entry_next.first      = item.first_of_packet;
        entry_next.last       = item.last_of_packet;
        entry_next.pseudo     = item.use_pseudo_header;
        entry_next.pseudo_sum = item.use_pseudo_header ? oc_fold(pseudo_total) : 16'h0000;
    end

    assign valid_next = accept ? 1'b1 : (valid_reg && qstat.full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule
`default_nettype wire

[hdl/icph_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icph_queue: short queue between front end and back end
// Circular buffer of classified bytes; push and pop may fall in one cycle.
// ----------------------------------------------------------------------------
module icph_queue
    import icph_pkg::*;
#(
    parameter int unsigned Depth = QueueDepthDefault
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire icph_entry_t push_entry,
    input  wire logic        pop,
    output icph_entry_t      head,
    output icph_qstat_t      qstat
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    icph_entry_t         slots [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [CntW-1:0]     count_reg;
    logic [CntW-1:0]     count_next;

    assign qstat.full  = (count_reg == CntW'(Depth));
    assign qstat.empty = (count_reg == '0);
    assign head        = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    // The front end only pushes into a queue with room left.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("queue pushed while full");

    // The back end only pops an entry that is there.
    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("queue popped while empty");

endmodule
`default_nettype wire

[hdl/icph_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// icph_back: accumulation stage of the checksum block
// Pairs bytes into words, keeps the end-around-carry sum and byte count and
// holds the finished checksum in an output register.
// ----------------------------------------------------------------------------
module icph_back
    import icph_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire icph_entry_t head,
    input  wire icph_qstat_t qstat,
    output logic             pop,
    output icph_out_t        result,
    output logic             result_valid,
    input  wire logic        result_stall
);

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        odd_reg;
    logic        odd_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        pseudo_reg;
    logic        pseudo_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    icph_out_t   out_reg;

    logic [15:0] base;
    logic        odd_eff;
    logic        pseudo_eff;
    logic [15:0] count_inc;
    logic [15:0] word;
    logic [15:0] len_word;
    logic [15:0] folded;
    logic        slot_free;

    assign slot_free    = !out_valid_reg || !result_stall;
    assign pop          = !qstat.empty && (!head.last || slot_free);
    assign result       = out_reg;
    assign result_valid = out_valid_reg;

    // A first byte starts from the pseudo header sum and cleared pairing.
    always_comb
    begin
        base       = head.first ? head.pseudo_sum : sum_reg;
        odd_eff    = head.first ? 1'b0 : odd_reg;
        pseudo_eff = head.first ? head.pseudo : pseudo_reg;
        count_inc  = (head.first ? 16'h0000 : count_reg) + 16'h0001;
        if (odd_eff)
        begin
            word = {held_reg, head.data_byte};
        end
        else if (head.last)
        begin
            word = {head.data_byte, 8'h00};
        end
        else
        begin
            word = 16'h0000;
        end
        len_word = (head.last && pseudo_eff) ? count_inc : 16'h0000;
        folded   = oc_fold(19'(base) + 19'(word) + 19'(len_word));
    end

    always_comb
    begin
        sum_next    = sum_reg;
        held_next   = held_reg;
        odd_next    = odd_reg;
        count_next  = count_reg;
        pseudo_next = pseudo_reg;
        if (pop)
        begin
            if (head.last)
            begin
                sum_next    = 16'h0000;
                odd_next    = 1'b0;
                count_next  = 16'h0000;
                pseudo_next = 1'b0;
            end
            else
            begin
                sum_next    = folded;
                odd_next    = !odd_eff;
                count_next  = count_inc;
                pseudo_next = pseudo_eff;
                if (!odd_eff)
                begin
                    held_next = head.data_byte;
                end
            end
        end
    end

    assign out_valid_next = (pop && head.last) ? 1'b1 : (out_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= 16'h0000;
            held_reg      <= 8'h00;
            odd_reg       <= 1'b0;
            count_reg     <= 16'h0000;
            pseudo_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            count_reg     <= count_next;
            pseudo_reg    <= pseudo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.last)
        begin
            out_reg.checksum   <= ~folded;
            out_reg.byte_count <= count_inc;
        end
    end

    // Every last byte taken from the queue shows up as a result.
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> out_valid_reg)
        else $error("last byte consumed without a result");

    // A finished packet leaves the packet state cleared.
    a_last_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> (count_reg == 16'h0000 && !odd_reg && sum_reg == 16'h0000))
        else $error("packet state not cleared after last byte");

endmodule
`default_nettype wire

[hdl/internet_checksum_pseudo_header.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// internet_checksum_pseudo_header: streaming Internet checksum
// Sums a packet byte by byte as big-endian 16-bit words in ones' complement,
// optionally with the IPv4 pseudo header, and gives the inverted checksum
// and byte count on the last byte.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                   | Payload
//   --------+-----------------------------+-----------------------------------
//   item    | item_valid / item_stall     | icph_in_t: one byte plus framing
//   result  | result_valid / result_stall | icph_out_t: checksum, byte_count
//
// The block takes one byte per clock while nothing stalls: a single
// three-operand add with end-around fold in the back end closes every byte.
// With no stalls, the last byte goes from the input register through a queue
// slot into the output register, which then holds the result.
// Reset clears the packet state, the queue and both valid flags.
// A stalled result only holds up a later last byte; the queue lets bytes
// keep flowing into the front end until it fills.
//
// The front end registers each byte and folds the five pseudo header words
// (both halves of each address and the protocol) into one 16-bit value on
// a first byte. The back end pairs bytes into words, pads an odd final byte
// with a zero low byte and adds the byte count for a pseudo header packet.
// ----------------------------------------------------------------------------
module internet_checksum_pseudo_header
    import icph_pkg::*;
#(
    parameter int unsigned QueueDepth = QueueDepthDefault
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire icph_in_t  item,
    input  wire logic      item_valid,
    output logic           item_stall,
    output icph_out_t      result,
    output logic           result_valid,
    input  wire logic      result_stall
);

    icph_qstat_t qstat;
    logic        push;
    logic        pop;
    icph_entry_t push_entry;
    icph_entry_t head;

    icph_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    icph_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    icph_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the streaming Internet checksum block
// Streams packets byte by byte through the block under random idling on both
// sides. A bit-exact software copy of the checksum state predicts every
// result, and each finished checksum is compared field by field with it.
// ----------------------------------------------------------------------------

// Tracks the running checksum of the packet in flight and holds the results
// that the block still owes, oldest first.
class checksum_tracker;

    logic [15:0] running_sum;
    logic [7:0]  held_high_byte;
    bit          odd_position;
    logic [15:0] length_count;
    bit          pseudo_active;

    icph_pkg::icph_out_t expected_checksums[$];
    int unsigned         mismatches;
    int unsigned         checksums_seen;

    function new();
        running_sum    = '0;
        held_high_byte = '0;
        odd_position   = 1'b0;
        length_count   = '0;
        pseudo_active  = 1'b0;
        mismatches     = 0;
        checksums_seen = 0;
    endfunction

    // Ones'-complement addition of two words with the carry wrapped round.
    function logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[15:0] + {15'd0, total[16]};
    endfunction

    function int unsigned outstanding();
        return expected_checksums.size();
    endfunction

    // Prints one line for a mismatch and counts it.
    task report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Folds one accepted byte into the state and queues a result on a last byte.
    function void note_transfer(input icph_pkg::icph_in_t it);
        logic [15:0]         sum;
        icph_pkg::icph_out_t outcome;
        if (it.first_of_packet) begin
            running_sum    = '0;
            held_high_byte = '0;
            odd_position   = 1'b0;
            length_count   = '0;
            pseudo_active  = it.use_pseudo_header;
            if (pseudo_active) begin
                running_sum = ones_add(running_sum, it.source_address[31:16]);
                running_sum = ones_add(running_sum, it.source_address[15:0]);
                running_sum = ones_add(running_sum, it.dest_address[31:16]);
                running_sum = ones_add(running_sum, it.dest_address[15:0]);
                running_sum = ones_add(running_sum, {8'h00, it.protocol});
            end
        end
        if (odd_position) begin
            running_sum  = ones_add(running_sum, {held_high_byte, it.data_byte});
            odd_position = 1'b0;
        end
        else begin
            held_high_byte = it.data_byte;
            odd_position   = 1'b1;
        end
        length_count = length_count + 16'd1;
        if (it.last_of_packet) begin
            sum = running_sum;
            if (odd_position)
                sum = ones_add(sum, {held_high_byte, 8'h00});
            if (pseudo_active)
                sum = ones_add(sum, length_count);
            outcome.checksum   = ~sum;
            outcome.byte_count = length_count;
            expected_checksums.push_back(outcome);
            running_sum   = '0;
            odd_position  = 1'b0;
            length_count  = '0;
            pseudo_active = 1'b0;
        end
    endfunction

    // Compares one accepted result with the oldest expectation.
    task check_result(input icph_pkg::icph_out_t got);
        icph_pkg::icph_out_t want;
        checksums_seen++;
        if (expected_checksums.size() == 0) begin
            report($sformatf("unexpected result checksum=%h byte_count=%0d",
                             got.checksum, got.byte_count));
        end
        else begin
            want = expected_checksums.pop_front();
            if (got.checksum !== want.checksum)
                report($sformatf("checksum %h, expected %h (byte_count %0d)",
                                 got.checksum, want.checksum, want.byte_count));
            if (got.byte_count !== want.byte_count)
                report($sformatf("byte_count %0d, expected %0d",
                                 got.byte_count, want.byte_count));
        end
    endtask

endclass

module tb_top;

    import icph_pkg::*;

    localparam int unsigned RANDOM_BYTES_PER_PHASE = 140;
    // Cycles without a single transfer on either channel before giving up.
    // A correct run never comes near this, even at the heaviest stalling.
    localparam int unsigned WATCHDOG_LIMIT         = 2000;
    // Time for the block to answer after the last byte, with some slack.
    localparam int unsigned SETTLE_CYCLES          = 10;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    icph_in_t   item         = '0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    icph_out_t  result;
    logic       result_valid;
    logic       result_stall = 1'b0;

    int unsigned sender_idle_pct    = 35;
    int unsigned receiver_stall_pct = 53;
    int unsigned bytes_sent         = 0;
    int unsigned quiet_cycles       = 0;

    checksum_tracker tracker;

    internet_checksum_pseudo_header dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always #2 clk = ~clk;

    // The result side: a transfer happens at an edge where valid is high and
    // our stall is low. The stall for the next cycle is then drawn afresh, so
    // that stalls land on every phase of the block's work.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
            tracker.check_result(result);
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    // The watchdog counts cycles in which neither channel completes a
    // transfer. Any hang in the block or the handshake ends the run here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timed out: no transfer for %0d cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Mostly random values, with the all-zero and all-one patterns mixed in
    // so that the end-around carry is exercised hard.
    function automatic logic [31:0] pick_address();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offers one byte to the block, after a random number of idle cycles, and
    // waits for its transfer. Valid stays high and the payload stays put for
    // as long as the block stalls. Each call leaves exactly one assignment to
    // item_valid in the time step of the transfer at most.
    task automatic send_byte(input logic [7:0] data, input bit first, input bit last,
                             input bit pseudo, input logic [31:0] saddr,
                             input logic [31:0] daddr, input logic [7:0] proto);
        icph_in_t next_item;
        next_item.data_byte         = data;
        next_item.first_of_packet   = first;
        next_item.last_of_packet    = last;
        next_item.use_pseudo_header = pseudo;
        next_item.source_address    = saddr;
        next_item.dest_address      = daddr;
        next_item.protocol          = proto;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item       <= next_item;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        tracker.note_transfer(next_item);
        bytes_sent++;
    endtask

    // Sends a run of random bytes. The pseudo header fields on every byte
    // but a first one are random too, as the block must ignore them there.
    task automatic send_random_packet(input int unsigned len, input bit with_first,
                                      input bit with_last, input bit pseudo);
        for (int unsigned i = 0; i < len; i++)
            send_byte(pick_byte(), with_first && i == 0, with_last && i == len - 1,
                      (i == 0) ? pseudo : 1'($urandom_range(1)),
                      pick_address(), pick_address(), pick_byte());
    endtask

    // One slice of random traffic. Most of it is well-formed packets with
    // random content; the rest is bytes outside a started packet, packets
    // cut short by a new first byte, and bytes with random framing.
    task automatic send_random_traffic();
        int unsigned kind;
        int unsigned len;
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 1);
            send_random_packet(len, 1'b1, 1'b1, 1'($urandom_range(1)));
        end
        else if (kind < 88)
            send_random_packet($urandom_range(4, 1), 1'b0, 1'b1, 1'b0);
        else if (kind < 94)
            send_random_packet($urandom_range(5, 1), 1'b1, 1'b0, 1'($urandom_range(1)));
        else
            repeat ($urandom_range(3, 1))
                send_byte(pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), pick_address(), pick_address(),
                          pick_byte());
    endtask

    // The sender holds off until the block has delivered every checksum owed.
    task automatic wait_for_checksums();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.outstanding() != 0);
    endtask

    initial
    begin
        int unsigned phase_end;
        tracker = new();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the first idling mix.
        // Bytes straight after reset with no first byte form a plain packet.
        send_random_packet(3, 1'b0, 1'b1, 1'b0);
        // One-byte packets: all ones with the pseudo header, then all zeros
        // without it, whose checksum is all ones.
        send_byte(8'hff, 1'b1, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        send_byte(8'h00, 1'b1, 1'b1, 1'b0, 32'h0000_0000, 32'h0000_0000, 8'h00);
        // Zero pseudo header and zero data, so that only the length counts.
        send_byte(8'h00, 1'b1, 1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000, 8'h00);
        send_byte(8'h00, 1'b0, 1'b1, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        // An odd-length packet with the pseudo header: the final byte is padded.
        send_random_packet(3, 1'b1, 1'b1, 1'b1);
        // Bytes after a last byte but without a new first byte.
        send_random_packet(2, 1'b0, 1'b1, 1'b1);
        // A packet cut short by a new first byte in its middle.
        send_random_packet(2, 1'b1, 1'b0, 1'b0);
        send_random_packet(2, 1'b1, 1'b1, 1'b1);
        // All-ones words fold to all ones, so the checksum comes out as zero.
        for (int i = 0; i < 4; i++)
            send_byte(8'hff, i == 0, i == 3, 1'b0, pick_address(), pick_address(),
                      pick_byte());
        // Pseudo header and data all ones: carries on every addition.
        for (int i = 0; i < 5; i++)
            send_byte(8'hff, i == 0, i == 4, 1'b1, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
        wait_for_checksums();

        // Random part in three idling mixes: sender light and receiver heavy,
        // then the reverse, then no idling at all.
        for (int phase = 0; phase < 3; phase++)
        begin
            sender_idle_pct    = (phase == 0) ? 35 : (phase == 1) ? 53 : 0;
            receiver_stall_pct = (phase == 0) ? 53 : (phase == 1) ? 35 : 0;
            phase_end = bytes_sent + RANDOM_BYTES_PER_PHASE;
            while (bytes_sent < phase_end)
                send_random_traffic();
            wait_for_checksums();
        end

        // Any stray result in these cycles is caught by the result checker.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.outstanding() != 0)
            tracker.report($sformatf("%0d checksums never arrived", tracker.outstanding()));

        $display("Run covered %0d byte transfers and %0d checksums under three idling mixes,",
                 bytes_sent, tracker.checksums_seen);
        $display("with stray bytes and broken framing mixed in; %0d mismatches.",
                 tracker.mismatches);
        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hdl/icph_pkg.sv
hdl/icph_front.sv
hdl/icph_queue.sv
hdl/icph_back.sv
hdl/internet_checksum_pseudo_header.sv
tb/tb_top.sv
